/* hw/rtl/duplicate_value_detector_top_assert.svh */
// Assertion macros used by the checker of the duplicate value detector.
`ifndef DUPLICATE_VALUE_DETECTOR_TOP_ASSERT_SVH
`define DUPLICATE_VALUE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define DVD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("duplicate value detector check failed");

// Next-cycle implication, disabled while rst is high.
`define DVD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("duplicate value detector check failed");

`endif

/* hw/rtl/dvd_pkg.sv */
package dvd_pkg;

   // Width of a value and depth of the seen-map.
   localparam int VALUE_BITS = 10;
   localparam int MAP_DEPTH  = 1 << VALUE_BITS;

   // Each seen-map entry holds the epoch of the set that last marked it.
   // Epoch zero is written by the clearing pass and never used by a set.
   localparam int EPOCH_BITS = 12;
   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};
   localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;

   // Register file of the configuration port.
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = CSR_ADDR_BITS - 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_VALUE = CSR_INDEX_BITS'(0);
   localparam logic [VALUE_BITS-1:0] MAX_VALUE_RESET = {VALUE_BITS{1'b1}};

   // Control state: sweeping the seen-map, or taking values.
   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } dvd_state_type;

endpackage

/* hw/rtl/dvd_req_if.sv */
interface dvd_req_if;
   logic                            valid;
   logic                            ready;
   logic [dvd_pkg::VALUE_BITS-1:0]  value;
   logic                            last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

/* hw/rtl/dvd_rsp_if.sv */
interface dvd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [dvd_pkg::VALUE_BITS-1:0]  dup_value;
   logic                            bad_value;

   modport source (output valid, output found, output dup_value, output bad_value,
                   input ready);
   modport sink   (input valid, input found, input dup_value, input bad_value,
                   output ready);
endinterface

/* hw/rtl/dvd_ram.sv */
module dvd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; a read of the address being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/duplicate_value_detector_top.sv */
// Duplicate value detector.
// A set of values arrives on req_chan, one value per transaction, with last
// marking the final value of the set. Legal values are 1 to max_value, which
// is register 0 of the csr_ port. For each set one transaction leaves on
// rsp_chan: found, the first value met twice (zero if none), and bad_value if
// any value of the set was out of range. Throughput is one value per cycle
// but for the stalls below. A result is registered as its last value leaves
// stage one. The seen-map is a 1024-entry RAM of epoch tags, read on intake
// and written as a value leaves stage one, with a forwarding register between
// neighboring values; a new set only bumps the epoch. After reset, and after
// every 4095 sets when the epoch wraps, a clearing pass writes the whole RAM,
// during which req_chan.ready is low. Configuration writes are taken at all
// times. A waiting result does not stop the intake; besides the clearing pass,
// only a last value that finds the result register still full and not taken,
// or that wraps the epoch, holds req_chan.ready low.
module duplicate_value_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   dvd_req_if.sink                             req_chan,
   dvd_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dvd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [dvd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [dvd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import dvd_pkg::*;

   dvd_state_type            state_ff, state_in;
   logic [VALUE_BITS-1:0]    clear_addr_ff, clear_addr_in;
   logic [EPOCH_BITS-1:0]    epoch_ff, epoch_in;
   logic [VALUE_BITS-1:0]    max_value_ff, max_value_in;

   logic                     s1_valid_ff, s1_valid_in;
   logic [VALUE_BITS-1:0]    s1_value_ff, s1_value_in;
   logic                     s1_last_ff, s1_last_in;
   logic                     fwd_hit_ff, fwd_hit_in;
   logic [EPOCH_BITS-1:0]    fwd_epoch_ff, fwd_epoch_in;

   logic                     found_ff, found_in;
   logic [VALUE_BITS-1:0]    dup_ff, dup_in;
   logic                     bad_ff, bad_in;

   logic                     out_valid_ff, out_valid_in;
   logic                     out_found_ff, out_found_in;
   logic [VALUE_BITS-1:0]    out_dup_ff, out_dup_in;
   logic                     out_bad_ff, out_bad_in;

   logic                     ram_wr_en;
   logic [VALUE_BITS-1:0]    ram_wr_addr;
   logic [EPOCH_BITS-1:0]    ram_wr_data;
   logic [EPOCH_BITS-1:0]    ram_rd_data;

   logic                     accept;
   logic                     s1_in_range;
   logic                     s1_seen;
   logic                     s1_commit;
   logic                     s1_close;
   logic                     wrap;
   logic                     csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;

   // Seen-map: one epoch tag per value.
   dvd_ram #(
      .WIDTH (EPOCH_BITS),
      .DEPTH (MAP_DEPTH)
   ) u_seen_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_chan.value),
      .rd_data (ram_rd_data)
   );

   // Lookup of the value held in stage one. A write to the same entry in the
   // cycle of its read is taken from the forwarding register.
   always_comb begin
      s1_in_range = (s1_value_ff != '0) && (s1_value_ff <= max_value_ff);
      s1_seen     = fwd_hit_ff ? (fwd_epoch_ff == epoch_ff) : (ram_rd_data == epoch_ff);
      s1_commit   = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_chan.ready);
      s1_close    = s1_commit && s1_last_ff;
      wrap        = s1_close && (epoch_ff == EPOCH_MAX);
   end

   // Control state machine: clearing pass, intake and seen-map write port.
   always_comb begin
      state_in       = state_ff;
      clear_addr_in  = clear_addr_ff;
      req_chan.ready = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = s1_value_ff;
      ram_wr_data    = epoch_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = clear_addr_ff;
            ram_wr_data   = EPOCH_CLEAR;
            clear_addr_in = clear_addr_ff + VALUE_BITS'(1);
            if (clear_addr_ff == {VALUE_BITS{1'b1}}) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req_chan.ready = !s1_valid_ff || (s1_commit && !wrap);
            ram_wr_en      = s1_commit && s1_in_range;
            if (wrap) begin
               state_in      = ST_CLEAR;
               clear_addr_in = '0;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign accept = req_chan.valid && req_chan.ready;

   // Stage one register, set flags and result register.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_value_in  = s1_value_ff;
      s1_last_in   = s1_last_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_epoch_in = fwd_epoch_ff;
      found_in     = found_ff;
      dup_in       = dup_ff;
      bad_in       = bad_ff;
      epoch_in     = epoch_ff;
      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_dup_in   = out_dup_ff;
      out_bad_in   = out_bad_ff;

      if (accept) begin
         s1_valid_in  = 1'b1;
         s1_value_in  = req_chan.value;
         s1_last_in   = req_chan.last;
         fwd_hit_in   = ram_wr_en && (ram_wr_addr == req_chan.value);
         fwd_epoch_in = ram_wr_data;
      end else if (s1_commit) begin
         s1_valid_in = 1'b0;
      end

      if (s1_commit) begin
         if (!s1_in_range) begin
            bad_in = 1'b1;
         end else if (s1_seen && !found_ff) begin
            found_in = 1'b1;
            dup_in   = s1_value_ff;
         end
      end

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      // The last value of a set closes it and starts a new epoch.
      if (s1_close) begin
         out_valid_in = 1'b1;
         out_found_in = found_in;
         out_dup_in   = found_in ? dup_in : '0;
         out_bad_in   = bad_in;
         found_in     = 1'b0;
         dup_in       = '0;
         bad_in       = 1'b0;
         epoch_in     = wrap ? EPOCH_FIRST : epoch_ff + EPOCH_BITS'(1);
      end
   end

   // Configuration read and write decoder.
   always_comb begin
      csr_write    = csr_psel && csr_penable && csr_pwrite;
      csr_index    = csr_paddr[CSR_ADDR_BITS-1:2];
      max_value_in = max_value_ff;
      csr_prdata   = '0;
      unique case (csr_index)
         REG_MAX_VALUE: begin
            csr_prdata = CSR_DATA_BITS'(max_value_ff);
            if (csr_write) begin
               max_value_in = csr_pwdata[VALUE_BITS-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         epoch_ff      <= EPOCH_FIRST;
         max_value_ff  <= MAX_VALUE_RESET;
         s1_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         dup_ff        <= '0;
         bad_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         epoch_ff      <= epoch_in;
         max_value_ff  <= max_value_in;
         s1_valid_ff   <= s1_valid_in;
         found_ff      <= found_in;
         dup_ff        <= dup_in;
         bad_ff        <= bad_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_value_ff  <= s1_value_in;
      s1_last_ff   <= s1_last_in;
      fwd_hit_ff   <= fwd_hit_in;
      fwd_epoch_ff <= fwd_epoch_in;
      out_found_ff <= out_found_in;
      out_dup_ff   <= out_dup_in;
      out_bad_ff   <= out_bad_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.found     = out_found_ff;
   assign rsp_chan.dup_value = out_dup_ff;
   assign rsp_chan.bad_value = out_bad_ff;

endmodule

/* hw/rtl/dvd_checker.sv */
`include "duplicate_value_detector_top_assert.svh"

module dvd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [dvd_pkg::VALUE_BITS-1:0]     rsp_dup_value
);
   import dvd_pkg::*;

   // A result that is not taken stays offered.
   `DVD_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Without a duplicate the reported value is zero.
   `DVD_ASSERT_NOW(a_dup_zero, clock, reset, rsp_valid && !rsp_found, rsp_dup_value == '0)

   // A duplicate is always a legal value, so never zero.
   `DVD_ASSERT_NOW(a_dup_legal, clock, reset, rsp_valid && rsp_found, rsp_dup_value != '0)

   // Reset starts the clearing pass: no intake and no result right after it.
   `DVD_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !req_ready && !rsp_valid)

endmodule

bind duplicate_value_detector_top dvd_checker u_dvd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_found     (rsp_chan.found),
   .rsp_dup_value (rsp_chan.dup_value)
);
